FILE: design/sorted_linked_list_engine_defines.svh
// Assertion macros shared by the sorted linked list engine.
`ifndef SORTED_LINKED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LINKED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define SLL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SLL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SLL_ASSERT(label, prop, msg)
`define SLL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: design/sll_pkg.sv
// Types, constants and helpers of the sorted linked list engine.
package sll_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned SLOT_W = $clog2(SLOTS + 1);
  localparam int unsigned VAL_W  = 32;

  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(SLOTS);

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } sll_req_t;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot_index;
    logic [SLOT_W-1:0] entry_count;
  } sll_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_ACT,
    ST_FREE_RD,
    ST_LINK_FRESH,
    ST_LINK_PREV,
    ST_LINK_CUR,
    ST_FIN
  } state_e;

  function automatic logic slot_valid(input logic [SLOT_W-1:0] s);
    return s < SLOT_NONE;
  endfunction

endpackage

FILE: design/sll_ram.sv
// Generic single write, single read port RAM with registered read data.
module sll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/sorted_linked_list_engine.sv
// Sorted linked list engine: a pool of 64 slots holding an ascending list of signed keys.
//
// Each request on the input channel carries an operation (search, insert, remove,
// clear) and a signed 32-bit key. Every request yields exactly one response with a
// success flag, the slot touched (64 when none) and the entry count afterward.
// Both channels use valid and ready; one request is in progress at a time.
// A request walks the list from its head, one slot per cycle, because each hop
// needs one read of the value and link memories. The response follows the walk
// and, for an insert or remove, the free list read and link writes; a clear goes
// straight to the response. The next request is accepted in the cycle after the
// response is registered. The response sits in an output register; while the
// receiver stalls, the engine finishes the next request and holds it until the
// register is free. Reset empties the list; slots never handed out since reset or
// clear are tracked by a fill counter, so no memory sweep is needed.
module sorted_linked_list_engine
  import sll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sll_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sll_rsp_t out_rsp_o
);

`include "sorted_linked_list_engine_defines.svh"

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic [SLOT_W-1:0] cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d, fresh_q, fresh_d;
  logic found_q, found_d;
  logic [SLOT_W-1:0] head_q, head_d, free_head_q, free_head_d;
  logic [SLOT_W-1:0] fill_q, fill_d, count_q, count_d;
  logic ok_q, ok_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic out_valid_q, out_valid_d;
  sll_rsp_t out_rsp_q, out_rsp_d;

  logic              val_we, link_we;
  logic [IDX_W-1:0]  val_waddr, link_waddr, raddr;
  logic [VAL_W-1:0]  val_wdata, val_rdata;
  logic [SLOT_W-1:0] link_wdata, link_rdata, raddr_full, bump_next;
  logic              less, out_free, ins_fail, bump;

  sll_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .raddr_i(raddr),
    .rdata_o(val_rdata)
  );

  sll_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(raddr),
    .rdata_o(link_rdata)
  );

  assign less      = $signed(val_rdata) < key_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign ins_fail  = !slot_valid(free_head_q) || found_q;
  assign bump      = free_head_q == fill_q;
  assign bump_next = (fill_q == SLOT_W'(SLOTS - 1)) ? SLOT_NONE : fill_q + SLOT_W'(1);
  assign raddr     = raddr_full[IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.op == OP_CLEAR) begin
            state_d = ST_FIN;
          end else if (slot_valid(head_q)) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_ACT;
          end
        end
      end
      ST_WALK: begin
        if (!(less && slot_valid(link_rdata))) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        case (op_q)
          OP_INSERT: begin
            if (ins_fail) begin
              state_d = ST_FIN;
            end else if (bump) begin
              state_d = ST_LINK_FRESH;
            end else begin
              state_d = ST_FREE_RD;
            end
          end
          OP_REMOVE: begin
            if (!found_q) begin
              state_d = ST_FIN;
            end else if (slot_valid(prev_q)) begin
              state_d = ST_LINK_PREV;
            end else begin
              state_d = ST_LINK_CUR;
            end
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_FREE_RD: state_d = ST_LINK_FRESH;
      ST_LINK_FRESH: state_d = slot_valid(prev_q) ? ST_LINK_PREV : ST_FIN;
      ST_LINK_PREV: state_d = (op_q == OP_INSERT) ? ST_FIN : ST_LINK_CUR;
      ST_LINK_CUR: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    fresh_d     = fresh_q;
    found_d     = found_q;
    head_d      = head_q;
    free_head_d = free_head_q;
    fill_d      = fill_q;
    count_d     = count_q;
    ok_d        = ok_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    val_we      = 1'b0;
    val_waddr   = fresh_q[IDX_W-1:0];
    val_wdata   = key_q;
    link_we     = 1'b0;
    link_waddr  = fresh_q[IDX_W-1:0];
    link_wdata  = cur_q;
    raddr_full  = free_head_q;
    case (state_q)
      ST_IDLE: begin
        raddr_full = head_q;
        if (in_valid_i) begin
          op_d    = in_req_i.op;
          key_d   = in_req_i.value;
          prev_d  = SLOT_NONE;
          cur_d   = head_q;
          found_d = 1'b0;
          if (in_req_i.op == OP_CLEAR) begin
            head_d      = SLOT_NONE;
            free_head_d = '0;
            fill_d      = '0;
            count_d     = '0;
            ok_d        = 1'b1;
            slot_d      = SLOT_NONE;
          end
        end
      end
      ST_WALK: begin
        raddr_full = link_rdata;
        if (less) begin
          prev_d = cur_q;
          cur_d  = slot_valid(link_rdata) ? link_rdata : SLOT_NONE;
        end else begin
          found_d = val_rdata == key_q;
          nxt_d   = link_rdata;
        end
      end
      ST_ACT: begin
        ok_d   = 1'b0;
        slot_d = SLOT_NONE;
        case (op_q)
          OP_SEARCH: begin
            ok_d   = found_q;
            slot_d = found_q ? cur_q : SLOT_NONE;
          end
          OP_INSERT: begin
            if (!ins_fail) begin
              ok_d    = 1'b1;
              slot_d  = free_head_q;
              fresh_d = free_head_q;
              if (bump) begin
                free_head_d = bump_next;
                fill_d      = fill_q + SLOT_W'(1);
              end
            end
          end
          OP_REMOVE: begin
            if (found_q) begin
              ok_d   = 1'b1;
              slot_d = cur_q;
              if (!slot_valid(prev_q)) begin
                head_d = nxt_q;
              end
            end
          end
          default: ;
        endcase
      end
      ST_FREE_RD: free_head_d = link_rdata;
      ST_LINK_FRESH: begin
        val_we  = 1'b1;
        link_we = 1'b1;
        count_d = count_q + SLOT_W'(1);
        if (!slot_valid(prev_q)) begin
          head_d = fresh_q;
        end
      end
      ST_LINK_PREV: begin
        link_we    = 1'b1;
        link_waddr = prev_q[IDX_W-1:0];
        link_wdata = (op_q == OP_INSERT) ? fresh_q : nxt_q;
      end
      ST_LINK_CUR: begin
        link_we     = 1'b1;
        link_waddr  = cur_q[IDX_W-1:0];
        link_wdata  = free_head_q;
        free_head_d = cur_q;
        count_d     = count_q - SLOT_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rsp_d   = '{success: ok_q, slot_index: slot_q, entry_count: count_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= SLOT_NONE;
      free_head_q <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    nxt_q     <= nxt_d;
    fresh_q   <= fresh_d;
    found_q   <= found_d;
    ok_q      <= ok_d;
    slot_q    <= slot_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `SLL_ASSERT(a_count_bound,
              count_q <= SLOT_NONE && fill_q <= SLOT_NONE,
              "count or fill overflow")
  `SLL_ASSERT(a_full_iff_no_free,
              (state_q == ST_IDLE) |->
                ((free_head_q == SLOT_NONE) == (count_q == SLOT_NONE)),
              "free list and count disagree")
  `SLL_ASSERT(a_empty_iff_no_head,
              (state_q == ST_IDLE) |-> ((head_q == SLOT_NONE) == (count_q == '0)),
              "list head and count disagree")
  `SLL_ASSERT(a_clear_empties,
              (in_valid_i && in_ready_o && in_req_i.op == OP_CLEAR) |=>
                (head_q == SLOT_NONE && count_q == '0 && state_q == ST_FIN),
              "clear did not empty the list")

endmodule
